[design/utfv_pkg.sv]
// ----------------------------------------------------------------------------
// utfv_pkg: shared types and constants of the utf-8 stream validator
// byte classes, queue entry layout, code point limits and queue sizing
// ----------------------------------------------------------------------------
package utfv_pkg;

    // byte classes produced by the front end
    typedef enum logic [2:0] {
        CLS_NONE  = 3'd0,   // no byte in this request
        CLS_ASCII = 3'd1,   // 01..7f
        CLS_BAD   = 3'd2,   // nul or a byte that cannot lead a sequence
        CLS_LEAD2 = 3'd3,   // c2..df
        CLS_LEAD3 = 3'd4,   // e0..ef
        CLS_LEAD4 = 3'd5    // f0..f4
    } t_cls;

    // one classified request as it sits in the queue
    typedef struct packed {
        t_cls       cls;
        logic       cont_ok;   // byte has the form 10xxxxxx
        logic [5:0] pay;       // payload bits, masked for the lead class
        logic       last;
    } t_item;

    // sequence kinds
    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_2B   = 2'd1;
    localparam logic [1:0] LEN_3B   = 2'd2;
    localparam logic [1:0] LEN_4B   = 2'd3;

    // byte ranges
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7F;
    localparam logic [7:0] LEAD2_LO       = 8'hC2;
    localparam logic [7:0] LEAD2_HI       = 8'hDF;
    localparam logic [7:0] LEAD3_LO       = 8'hE0;
    localparam logic [7:0] LEAD3_HI       = 8'hEF;
    localparam logic [7:0] LEAD4_LO       = 8'hF0;
    localparam logic [7:0] LEAD4_HI       = 8'hF4;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    // code point limits
    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] CP_MIN2    = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN3    = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4    = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00DFFF;

    // queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

endpackage

[design/utfv_front.sv]
// ----------------------------------------------------------------------------
// utfv_front: request intake and byte classification
// sorts each byte into a lead class and prepares its payload bits
// ----------------------------------------------------------------------------
module utfv_front (
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_present,
    input  logic               i_end_of_string,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output utfv_pkg::t_item    o_item
);

    utfv_pkg::t_cls w_cls;
    logic [5:0]     w_pay;

    always_comb begin
        if (!i_byte_present) begin
            w_cls = utfv_pkg::CLS_NONE;
        end else if (i_data_byte == utfv_pkg::BYTE_NUL) begin
            w_cls = utfv_pkg::CLS_BAD;
        end else if (i_data_byte <= utfv_pkg::BYTE_ASCII_MAX) begin
            w_cls = utfv_pkg::CLS_ASCII;
        end else if (i_data_byte >= utfv_pkg::LEAD2_LO && i_data_byte <= utfv_pkg::LEAD2_HI) begin
            w_cls = utfv_pkg::CLS_LEAD2;
        end else if (i_data_byte >= utfv_pkg::LEAD3_LO && i_data_byte <= utfv_pkg::LEAD3_HI) begin
            w_cls = utfv_pkg::CLS_LEAD3;
        end else if (i_data_byte >= utfv_pkg::LEAD4_LO && i_data_byte <= utfv_pkg::LEAD4_HI) begin
            w_cls = utfv_pkg::CLS_LEAD4;
        end else begin
            w_cls = utfv_pkg::CLS_BAD;
        end
    end

    // lead bytes keep only their value bits, anything else keeps six
    always_comb begin
        unique case (w_cls)
            utfv_pkg::CLS_LEAD2: w_pay = {1'b0, i_data_byte[4:0]};
            utfv_pkg::CLS_LEAD3: w_pay = {2'b00, i_data_byte[3:0]};
            utfv_pkg::CLS_LEAD4: w_pay = {3'b000, i_data_byte[2:0]};
            default:             w_pay = i_data_byte[5:0];
        endcase
    end

    assign o_ready        = !i_q_full;
    assign o_push         = i_valid && !i_q_full;
    assign o_item.cls     = w_cls;
    assign o_item.cont_ok = (i_data_byte[7:6] == utfv_pkg::CONT_TAG);
    assign o_item.pay     = w_pay;
    assign o_item.last    = i_end_of_string;

endmodule

[design/utfv_queue.sv]
// ----------------------------------------------------------------------------
// utfv_queue: short request queue between front and back
// circular buffer of classified requests with occupancy count
// ----------------------------------------------------------------------------
module utfv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  utfv_pkg::t_item    i_item,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output utfv_pkg::t_item    o_item
);

    utfv_pkg::t_item           r_mem [utfv_pkg::QDEPTH];
    logic [utfv_pkg::QAW-1:0]  r_wr_ptr;
    logic [utfv_pkg::QAW-1:0]  r_rd_ptr;
    logic [utfv_pkg::QCW-1:0]  r_count;
    logic [utfv_pkg::QAW-1:0]  n_wr_ptr;
    logic [utfv_pkg::QAW-1:0]  n_rd_ptr;
    logic [utfv_pkg::QCW-1:0]  n_count;
    logic                      w_do_pop;

    assign w_do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = i_push   ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == utfv_pkg::QCW'(utfv_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

[design/utfv_back.sv]
// ----------------------------------------------------------------------------
// utfv_back: sequence tracking and verdict
// updates the open sequence state per request and registers the result
// ----------------------------------------------------------------------------
module utfv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  utfv_pkg::t_item    i_item,
    output logic               o_pop,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_string_valid
);

    logic [1:0]                r_bytes_rem;
    logic [1:0]                r_seq_len;
    logic [utfv_pkg::CP_W-1:0] r_accum;
    logic                      r_failed;
    logic                      r_out_valid;
    logic                      r_out_data;

    logic [1:0]                n_bytes_rem;
    logic [1:0]                n_seq_len;
    logic [utfv_pkg::CP_W-1:0] n_accum;
    logic                      n_failed;
    logic                      n_out_valid;
    logic                      n_out_data;

    logic                      w_take;
    logic [utfv_pkg::CP_W-1:0] w_cp;
    logic [utfv_pkg::CP_W-1:0] w_min;
    logic                      w_cp_ok;

    // a last request needs room in the result register
    assign w_take = i_q_valid && (!r_out_valid || i_ready || !i_item.last);

    assign w_cp = {r_accum[utfv_pkg::CP_W-7:0], i_item.pay};

    always_comb begin
        unique case (r_seq_len)
            utfv_pkg::LEN_2B: w_min = utfv_pkg::CP_MIN2;
            utfv_pkg::LEN_3B: w_min = utfv_pkg::CP_MIN3;
            default:          w_min = utfv_pkg::CP_MIN4;
        endcase
    end

    assign w_cp_ok = (w_cp >= w_min) && (w_cp <= utfv_pkg::CP_MAX)
                   && !((w_cp >= utfv_pkg::CP_SURR_LO) && (w_cp <= utfv_pkg::CP_SURR_HI));

    always_comb begin
        n_bytes_rem = r_bytes_rem;
        n_seq_len   = r_seq_len;
        n_accum     = r_accum;
        n_failed    = r_failed;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;

        if (w_take) begin
            if (i_item.cls != utfv_pkg::CLS_NONE && !r_failed) begin
                if (r_bytes_rem != 2'd0) begin
                    // continuation expected
                    if (!i_item.cont_ok) begin
                        n_failed    = 1'b1;
                        n_bytes_rem = '0;
                        n_seq_len   = utfv_pkg::LEN_NONE;
                        n_accum     = '0;
                    end else if (r_bytes_rem == 2'd1) begin
                        n_failed    = !w_cp_ok;
                        n_bytes_rem = '0;
                        n_seq_len   = utfv_pkg::LEN_NONE;
                        n_accum     = '0;
                    end else begin
                        n_bytes_rem = r_bytes_rem - 2'd1;
                        n_accum     = w_cp;
                    end
                end else begin
                    unique case (i_item.cls)
                        utfv_pkg::CLS_LEAD2: begin
                            n_bytes_rem = 2'd1;
                            n_seq_len   = utfv_pkg::LEN_2B;
                            n_accum     = utfv_pkg::CP_W'(i_item.pay);
                        end
                        utfv_pkg::CLS_LEAD3: begin
                            n_bytes_rem = 2'd2;
                            n_seq_len   = utfv_pkg::LEN_3B;
                            n_accum     = utfv_pkg::CP_W'(i_item.pay);
                        end
                        utfv_pkg::CLS_LEAD4: begin
                            n_bytes_rem = 2'd3;
                            n_seq_len   = utfv_pkg::LEN_4B;
                            n_accum     = utfv_pkg::CP_W'(i_item.pay);
                        end
                        utfv_pkg::CLS_ASCII, utfv_pkg::CLS_NONE: begin
                        end
                        default: begin
                            n_failed = 1'b1;
                        end
                    endcase
                end
            end

            if (i_item.last) begin
                n_out_valid = 1'b1;
                n_out_data  = !n_failed && (n_bytes_rem == 2'd0);
                n_bytes_rem = '0;
                n_seq_len   = utfv_pkg::LEN_NONE;
                n_accum     = '0;
                n_failed    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_rem <= '0;
            r_seq_len   <= utfv_pkg::LEN_NONE;
            r_accum     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bytes_rem <= n_bytes_rem;
            r_seq_len   <= n_seq_len;
            r_accum     <= n_accum;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_pop          = w_take;
    assign o_valid        = r_out_valid;
    assign o_string_valid = r_out_data;

    // a failed string holds no open sequence
    a_fail_clears_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_bytes_rem == 2'd0 && r_seq_len == utfv_pkg::LEN_NONE))
        else $error("open sequence kept after failure");

    // bytes still expected never exceed the sequence kind
    a_rem_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_rem <= r_seq_len)
        else $error("bytes remaining exceed sequence length");

    // a new result only follows a taken last request
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_take && i_item.last))
        else $error("result without a last request");

endmodule

[design/utf8_stream_validator.sv]
// ----------------------------------------------------------------------------
// utf8_stream_validator: streaming utf-8 well-formedness check
// one byte per request, one verdict per string at the request marked last
// ----------------------------------------------------------------------------
// result path: a last request is written into the request queue, then taken by
//   the back end and its verdict registered in the result register; the back end
//   holds a last request while the result register is full and not being read
// throughput: one request per cycle while the request queue has room
// reset: synchronous active-low i_rst_n empties the queue, drops the result
//   and clears the sequence state; no clearing pass is needed
// ----------------------------------------------------------------------------
module utf8_stream_validator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_string,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_string_valid
);

    // front to queue
    logic            w_push;
    utfv_pkg::t_item w_front_item;
    logic            w_q_full;

    // queue to back
    logic            w_q_valid;
    utfv_pkg::t_item w_q_item;
    logic            w_pop;

    // front: classify the byte, accept whenever the queue has room
    utfv_front u_front (
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (w_q_full),
        .o_ready         (o_ready),
        .o_push          (w_push),
        .o_item          (w_front_item)
    );

    // queue decouples intake from a stalled result channel
    utfv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // back: track the open sequence, register the verdict
    utfv_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_string_valid (o_string_valid)
    );

endmodule

[test/utf8_stream_validator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_tb: self-checking bench for the utf-8 stream validator
// a queue of byte requests feeds a bursty driver, a bit-level predictor builds
// the expected verdict of every string and a monitor behind a stalling
// receiver compares each verdict with the oldest one still owed
// ----------------------------------------------------------------------------
module utf8_stream_validator_tb;

    localparam int unsigned N_REQ      = 700;     // byte or end requests in the random part
    localparam int unsigned CYC_LIMIT  = 200000;  // watchdog
    localparam int unsigned DRAIN_CYC  = 12;      // quiet cycles after the last verdict
    localparam int unsigned HOLD_CYC   = 300;     // long receiver hold-off
    localparam int unsigned MAX_REPORT = 10;

    // one request as the driver presents it
    typedef struct packed {
        logic [7:0] dat;
        logic       has_byte;
        logic       is_last;
    } t_req;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_data_byte     = 8'h00;
    logic       i_byte_present  = 1'b0;
    logic       i_end_of_string = 1'b0;
    logic       i_ready         = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_string_valid;

    // stimulus and scoreboard storage
    t_req        req_q[$];       // requests not yet presented
    logic        verdict_q[$];   // verdicts owed by the block, oldest first
    int unsigned n_real   = 0;   // requests that carry a byte or an end mark
    int unsigned n_total  = 0;   // every request, idle ones included
    int unsigned acc_cnt  = 0;   // requests accepted so far
    int unsigned err_cnt  = 0;
    int unsigned verd_cnt = 0;
    int unsigned cyc_cnt  = 0;

    // predictor state of the string in flight
    logic [1:0]                pend_cont  = 2'd0;                // continuation bytes still owed
    logic [1:0]                seq_kind   = utfv_pkg::LEN_NONE;  // kind of the open sequence
    logic [utfv_pkg::CP_W-1:0] cp_sofar   = '0;                  // code point bits so far
    logic                      str_broken = 1'b0;                // sticky failure of this string

    // driver and receiver pacing
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned rx_mode    = 0;
    int unsigned rx_cnt     = 0;
    logic        rx_pick    = 1'b0;
    logic        rx_hold    = 1'b0;
    t_req        nxt;

    utf8_stream_validator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_end_of_string (i_end_of_string),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_string_valid  (o_string_valid)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // drop the open sequence, keep the failure flag
    function automatic void drop_sequence();
        pend_cont = 2'd0;
        seq_kind  = utfv_pkg::LEN_NONE;
        cp_sofar  = '0;
    endfunction

    function automatic void fail_string();
        str_broken = 1'b1;
        drop_sequence();
    endfunction

    // finished code point: not overlong, not above the top, not a surrogate
    function automatic logic cp_legal(input logic [1:0] kind,
                                      input logic [utfv_pkg::CP_W-1:0] cp);
        logic [utfv_pkg::CP_W-1:0] floor_cp;
        case (kind)
            utfv_pkg::LEN_2B: floor_cp = utfv_pkg::CP_MIN2;
            utfv_pkg::LEN_3B: floor_cp = utfv_pkg::CP_MIN3;
            default:          floor_cp = utfv_pkg::CP_MIN4;
        endcase
        return !(cp < floor_cp || cp > utfv_pkg::CP_MAX
                 || (cp >= utfv_pkg::CP_SURR_LO && cp <= utfv_pkg::CP_SURR_HI));
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        // once broken, bytes are ignored until the end mark
        if (str_broken) return;
        if (pend_cont != 2'd0) begin
            if (b[7:6] != utfv_pkg::CONT_TAG) begin
                fail_string();
                return;
            end
            cp_sofar  = {cp_sofar[utfv_pkg::CP_W-7:0], b[5:0]};
            pend_cont = pend_cont - 2'd1;
            if (pend_cont == 2'd0) begin
                if (!cp_legal(seq_kind, cp_sofar)) fail_string();
                else drop_sequence();
            end
            return;
        end
        if (b == utfv_pkg::BYTE_NUL) begin
            fail_string();
        end else if (b <= utfv_pkg::BYTE_ASCII_MAX) begin
            // plain ascii, nothing to track
        end else if (b >= utfv_pkg::LEAD2_LO && b <= utfv_pkg::LEAD2_HI) begin
            pend_cont = 2'd1;
            seq_kind  = utfv_pkg::LEN_2B;
            cp_sofar  = utfv_pkg::CP_W'(b[4:0]);
        end else if (b >= utfv_pkg::LEAD3_LO && b <= utfv_pkg::LEAD3_HI) begin
            pend_cont = 2'd2;
            seq_kind  = utfv_pkg::LEN_3B;
            cp_sofar  = utfv_pkg::CP_W'(b[3:0]);
        end else if (b >= utfv_pkg::LEAD4_LO && b <= utfv_pkg::LEAD4_HI) begin
            pend_cont = 2'd3;
            seq_kind  = utfv_pkg::LEN_4B;
            cp_sofar  = utfv_pkg::CP_W'(b[2:0]);
        end else begin
            // stray continuation, c0/c1 or f5 and up
            fail_string();
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------

    task automatic push_req(input logic [7:0] d, input logic p, input logic l);
        t_req r;
        r.dat      = d;
        r.has_byte = p;
        r.is_last  = l;
        req_q = {req_q, r};
        if (p || l) n_real++;
    endtask

    // encode cp in nb bytes whatever its value, emit only the first keep bytes
    task automatic push_char(input int unsigned nb, input logic [20:0] cp,
                             input int unsigned keep);
        logic [7:0] enc [4];
        enc[1] = {utfv_pkg::CONT_TAG, cp[5:0]};
        enc[2] = enc[1];
        enc[3] = enc[1];
        case (nb)
            1: enc[0] = {1'b0, cp[6:0]};
            2: enc[0] = {3'b110, cp[10:6]};
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {utfv_pkg::CONT_TAG, cp[11:6]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {utfv_pkg::CONT_TAG, cp[17:12]};
                enc[2] = {utfv_pkg::CONT_TAG, cp[11:6]};
            end
        endcase
        for (int k = 0; k < keep; k++) push_req(enc[k], 1'b1, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // driver: presents queued requests in bursts, predicts on acceptance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            str_broken = 1'b0;
            drop_sequence();
        end else begin
            if (i_valid && o_ready) begin
                acc_cnt++;
                if (i_byte_present) absorb_byte(i_data_byte);
                // end mark: verdict owed, then a fresh string
                if (i_end_of_string) begin
                    verdict_q = {verdict_q, (!str_broken && pend_cont == 2'd0)};
                    str_broken = 1'b0;
                    drop_sequence();
                end
            end
            // a request still waiting for ready keeps valid and payload as is
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt = req_q.pop_front();
                    i_valid         <= 1'b1;
                    i_data_byte     <= nxt.dat;
                    i_byte_present  <= nxt.has_byte;
                    i_end_of_string <= nxt.is_last;
                    if (burst_left == 0) begin
                        // new burst, now and then a long one; a gap may follow its first request
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                                 : $urandom_range(0, 10);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: ready follows a pattern that is picked anew after a random number of cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (rx_cnt == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_cnt  = $urandom_range(8, 40);
            end else begin
                rx_cnt--;
            end
            case (rx_mode)
                0:       rx_pick = 1'b1;                         // always ready
                1:       rx_pick = 1'($urandom_range(0, 1));     // coin flip
                2:       rx_pick = ($urandom_range(0, 3) == 0);  // mostly stalled
                default: rx_pick = ~i_ready;                     // toggling
            endcase
            i_ready <= rx_pick && !rx_hold;
        end
    end

    // long hold-offs while the driver keeps pushing, so the block backs up
    initial begin
        for (int h = 0; h < 2; h++) begin
            while (acc_cnt < (h + 1) * 250) @(posedge i_clk);
            rx_hold <= 1'b1;
            for (int c = 0; c < HOLD_CYC; c++) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every verdict against the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORT)
                    $display("verdict %0d: none owed, got string_valid=%b",
                             verd_cnt, o_string_valid);
            end else if (o_string_valid !== verdict_q[0]) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORT)
                    $display("verdict %0d: string_valid expected %b got %b",
                             verd_cnt, verdict_q[0], o_string_valid);
            end
            if (verdict_q.size() != 0) void'(verdict_q.pop_front());
            verd_cnt++;
        end
    end

    // watchdog
    initial begin
        while (cyc_cnt < CYC_LIMIT) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned nchars;
        int unsigned bad_at;
        int unsigned kind;
        int unsigned str_start;
        logic        corrupt;
        logic [20:0] cp;
        t_req        tail;

        // directed strings
        push_req(8'hFF, 1'b0, 1'b1);                          // empty string
        push_req(utfv_pkg::BYTE_ASCII_MAX, 1'b1, 1'b0);       // top ascii, smallest two-byte,
        push_req(utfv_pkg::LEAD2_LO, 1'b1, 1'b0);             // end mark on a byte
        push_req(8'h80, 1'b1, 1'b1);
        push_req(utfv_pkg::BYTE_NUL, 1'b1, 1'b1);             // nul
        push_req(utfv_pkg::LEAD4_HI, 1'b1, 1'b0);             // highest code point
        push_req(8'h8F, 1'b1, 1'b0);
        push_req(8'hBF, 1'b1, 1'b0);
        push_req(8'hBF, 1'b1, 1'b1);
        push_req(8'hED, 1'b1, 1'b0);                          // surrogate
        push_req(8'hA0, 1'b1, 1'b0);
        push_req(8'h80, 1'b1, 1'b1);
        push_req(utfv_pkg::LEAD3_LO, 1'b1, 1'b0);             // overlong three-byte
        push_req(8'h9F, 1'b1, 1'b0);
        push_req(8'hBF, 1'b1, 1'b1);
        push_req(utfv_pkg::LEAD4_HI, 1'b1, 1'b0);             // just above the top
        push_req(8'h90, 1'b1, 1'b0);
        push_req(8'h80, 1'b1, 1'b0);
        push_req(8'h80, 1'b1, 1'b1);
        push_req(utfv_pkg::LEAD2_HI, 1'b1, 1'b0);             // bad continuation, then bytes
        push_req(utfv_pkg::BYTE_ASCII_MAX, 1'b1, 1'b0);       // that would be fine are ignored
        push_req(utfv_pkg::LEAD2_LO, 1'b1, 1'b0);
        push_req(8'h5A, 1'b0, 1'b0);                          // idle request
        push_req(8'h80, 1'b1, 1'b0);
        push_req(8'h00, 1'b0, 1'b1);
        push_req(8'hE2, 1'b1, 1'b0);                          // sequence cut off by the end mark
        push_req(8'h82, 1'b1, 1'b0);
        push_req(8'hA5, 1'b0, 1'b1);

        // random strings, mostly well formed, a quarter with one fault
        n_real = 0;
        while (n_real < N_REQ) begin
            str_start = req_q.size();
            nchars    = $urandom_range(0, 6);
            corrupt   = ($urandom_range(0, 3) == 0);
            bad_at    = $urandom_range(0, (nchars == 0) ? 0 : nchars - 1);
            for (int c = 0; c < nchars; c++) begin
                if ($urandom_range(0, 7) == 0)
                    push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                if (corrupt && c == bad_at) begin
                    case ($urandom_range(0, 6))
                        0: push_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                        1: push_req(utfv_pkg::BYTE_NUL, 1'b1, 1'b0);
                        2: begin    // overlong
                            kind = $urandom_range(2, 4);
                            cp   = 21'($urandom_range(0, (kind == 2) ? 'h7F :
                                                         (kind == 3) ? 'h7FF : 'hFFFF));
                            push_char(kind, cp, kind);
                        end
                        3: begin    // surrogate
                            cp = 21'($urandom_range(utfv_pkg::CP_SURR_LO,
                                                    utfv_pkg::CP_SURR_HI));
                            push_char(3, cp, 3);
                        end
                        4: begin    // above the top, leads up to f7
                            cp = 21'($urandom_range('h110000, 'h1FFFFF));
                            push_char(4, cp, 4);
                        end
                        5: begin    // truncated sequence
                            kind = $urandom_range(2, 4);
                            cp   = 21'($urandom_range(0, 'h1FFFFF));
                            push_char(kind, cp, $urandom_range(1, kind - 1));
                        end
                        default: begin    // lead then a byte that is no continuation
                            kind = $urandom_range(2, 4);
                            cp   = 21'($urandom_range(0, 'h1FFFFF));
                            push_char(kind, cp, $urandom_range(1, kind - 1));
                            cp[7:0] = 8'($urandom_range(0, 255));
                            if (cp[7:6] == utfv_pkg::CONT_TAG) cp[6] = 1'b1;
                            push_req(cp[7:0], 1'b1, 1'b0);
                        end
                    endcase
                end else begin
                    kind = $urandom_range(1, 4);
                    case (kind)
                        1: cp = 21'($urandom_range(1, 'h7F));
                        2: cp = 21'($urandom_range('h80, 'h7FF));
                        3: begin
                            cp = 21'($urandom_range('h800, 'hFFFF));
                            if (cp >= utfv_pkg::CP_SURR_LO && cp <= utfv_pkg::CP_SURR_HI)
                                cp = cp + 21'h800;
                        end
                        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
                    endcase
                    push_char(kind, cp, kind);
                end
            end
            // end mark on the final byte or as a bare marker
            if (req_q.size() > str_start && req_q[$].has_byte && $urandom_range(0, 1)) begin
                tail = req_q.pop_back();
                tail.is_last = 1'b1;
                req_q = {req_q, tail};
            end else begin
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
        end
        n_total = req_q.size();

        // reset, held low at the start of the run, then released
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests taken and every verdict seen, then a quiet tail
        while (acc_cnt != n_total || verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (err_cnt == 0 && verdict_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
